>>> sv/wgic_pkg.sv
// ----------------------------------------------------------------------------
// wgic_pkg
// Shared types and constants for the Wi-Fi generation element classifier.
// ----------------------------------------------------------------------------
package wgic_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned GEN_W  = 2;

    // Element IDs and HE extension IDs
    localparam logic [BYTE_W-1:0] IE_ID_HT_CAP   = 8'd45;
    localparam logic [BYTE_W-1:0] IE_ID_HT_OPER  = 8'd61;
    localparam logic [BYTE_W-1:0] IE_ID_VHT_OPER = 8'd192;
    localparam logic [BYTE_W-1:0] IE_ID_VHT_CAP  = 8'd191;
    localparam logic [BYTE_W-1:0] IE_ID_EXT      = 8'd255;
    localparam logic [BYTE_W-1:0] IE_EXT_HE_CAP  = 8'd35;
    localparam logic [BYTE_W-1:0] IE_EXT_HE_OPER = 8'd36;

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_EXT  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HT   = 2'd1,
        KIND_VHT  = 2'd2,
        KIND_HE   = 2'd3
    } t_kind;

    typedef enum logic [GEN_W-1:0] {
        GEN_LEGACY = 2'd0,
        GEN_HT     = 2'd1,
        GEN_VHT    = 2'd2,
        GEN_HE     = 2'd3
    } t_gen;

endpackage

>>> sv/wgic_if.sv
// ----------------------------------------------------------------------------
// wgic_if
// Valid/ready channels: element byte stream in, generation code out.
// ----------------------------------------------------------------------------
interface wgic_in_if import wgic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] ie_byte;
    logic              last;
    logic              end_only;

    modport source (output valid, ie_byte, last, end_only, input ready);
    modport sink   (input valid, ie_byte, last, end_only, output ready);
endinterface

interface wgic_out_if import wgic_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [GEN_W-1:0] generation;

    modport source (output valid, generation, input ready);
    modport sink   (input valid, generation, output ready);
endinterface

>>> sv/wifi_generation_ie_classifier.sv
// ----------------------------------------------------------------------------
// wifi_generation_ie_classifier
// Walks a frame's information-element list and reports its Wi-Fi generation.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one byte of the element list per item, with last marking
//   the final byte of the frame. An item with end_only set carries no byte
//   and only closes the frame (empty or null frame).
//   o_result carries one generation code per frame: 3 HE, 2 VHT, 1 HT,
//   0 legacy. Items that do not close a frame produce no result.
// Timing:
//   One item per cycle sustained while no held result blocks a closing item.
//   An item is held in the input register, where the element walker updates
//   its state; a frame close loads the result register.
// Reset:
//   i_rst_n low clears both registers' valid bits, the walker state and the
//   sticky flags. Each frame close also returns the walker to that state.
// Stall:
//   A held result blocks only the next closing item; bytes inside a frame
//   keep flowing. While the input register holds a blocked item, i_item
//   ready drops.
// ----------------------------------------------------------------------------
module wifi_generation_ie_classifier import wgic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wgic_in_if.sink    i_item,
    wgic_out_if.source o_result
);

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_in_end_only;

    // Walker state
    t_phase            r_phase,  n_phase;
    logic [BYTE_W-1:0] r_rem,    n_rem;
    logic [BYTE_W-1:0] r_cur_id, n_cur_id;
    t_kind             r_kind,   n_kind;
    logic              r_ht,     n_ht;
    logic              r_vht,    n_vht;
    logic              r_he,     n_he;

    // Result register
    logic              r_out_valid;
    t_gen              r_gen,    n_gen;

    logic close_frame;
    logic commit;
    logic out_free;
    logic advance;

    assign close_frame = r_in_end_only | r_in_last;
    assign out_free    = !r_out_valid || o_result.ready;
    assign advance     = r_in_valid && (!close_frame || out_free);

    assign i_item.ready        = !r_in_valid || advance;
    assign o_result.valid      = r_out_valid;
    assign o_result.generation = r_gen;

    // Element walker
    always_comb begin
        n_phase  = r_phase;
        n_rem    = r_rem;
        n_cur_id = r_cur_id;
        n_kind   = r_kind;
        n_ht     = r_ht;
        n_vht    = r_vht;
        n_he     = r_he;
        commit   = 1'b0;

        if (!r_in_end_only) begin
            unique case (r_phase)
                PH_ID: begin
                    n_cur_id = r_in_byte;
                    n_phase  = PH_LEN;
                end
                PH_LEN: begin
                    if (r_cur_id == IE_ID_HT_CAP || r_cur_id == IE_ID_HT_OPER) begin
                        n_kind = KIND_HT;
                    end else if (r_cur_id == IE_ID_VHT_CAP ||
                                 r_cur_id == IE_ID_VHT_OPER) begin
                        n_kind = KIND_VHT;
                    end else begin
                        n_kind = KIND_NONE;
                    end
                    n_rem = r_in_byte;
                    if (r_in_byte == '0) begin
                        commit = 1'b1;
                    end else begin
                        n_phase = (r_cur_id == IE_ID_EXT) ? PH_EXT : PH_BODY;
                    end
                end
                PH_EXT: begin
                    n_kind = (r_in_byte == IE_EXT_HE_CAP || r_in_byte == IE_EXT_HE_OPER)
                           ? KIND_HE : KIND_NONE;
                    n_rem  = r_rem - 1'b1;
                    if (n_rem == '0) begin
                        commit = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_rem != '0) begin
                        n_rem = r_rem - 1'b1;
                    end
                    if (n_rem == '0) begin
                        commit = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_ID;
                end
            endcase
        end

        // Element complete: latch its flag and expect the next ID
        if (commit) begin
            unique case (n_kind)
                KIND_HT:   n_ht  = 1'b1;
                KIND_VHT:  n_vht = 1'b1;
                KIND_HE:   n_he  = 1'b1;
                KIND_NONE: ;
                default:   ;
            endcase
            n_kind  = KIND_NONE;
            n_phase = PH_ID;
        end

        priority if (n_he) begin
            n_gen = GEN_HE;
        end else if (n_vht) begin
            n_gen = GEN_VHT;
        end else if (n_ht) begin
            n_gen = GEN_HT;
        end else begin
            n_gen = GEN_LEGACY;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_byte     <= i_item.ie_byte;
            r_in_last     <= i_item.last;
            r_in_end_only <= i_item.end_only;
        end
    end

    // Walker state: back to idle on frame close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID;
            r_rem    <= '0;
            r_cur_id <= '0;
            r_kind   <= KIND_NONE;
            r_ht     <= 1'b0;
            r_vht    <= 1'b0;
            r_he     <= 1'b0;
        end else if (advance) begin
            if (close_frame) begin
                r_phase  <= PH_ID;
                r_rem    <= '0;
                r_cur_id <= '0;
                r_kind   <= KIND_NONE;
                r_ht     <= 1'b0;
                r_vht    <= 1'b0;
                r_he     <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_rem    <= n_rem;
                r_cur_id <= n_cur_id;
                r_kind   <= n_kind;
                r_ht     <= n_ht;
                r_vht    <= n_vht;
                r_he     <= n_he;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && close_frame) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && close_frame) begin
            r_gen <= n_gen;
        end
    end

endmodule
